// ===== hw/rtl/gbm_pkg.sv =====
`default_nettype none

package gbm_pkg;

    localparam int CFG_W    = 32;
    localparam int VOL_W    = 31;
    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 32;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 2 * MUL_W;

    localparam logic [1:0] CFG_INITIAL_PRICE = 2'd0;
    localparam logic [1:0] CFG_STEP_DRIFT    = 2'd1;
    localparam logic [1:0] CFG_STEP_VOL      = 2'd2;

    localparam logic [31:0] INIT_PRICE_RESET = 32'd65536;

    localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;
    localparam logic [31:0] RECIP3_Q33 = 32'hAAAA_AAAB;

    localparam logic [31:0] Q428_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q428_MIN = 32'h8000_0000;

    localparam logic signed [7:0] K_MAX = 8'sd11;
    localparam logic signed [7:0] K_MIN = -8'sd12;
    localparam logic [5:0] SHIFT_BIAS   = 6'd30;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VZ,
        ST_X,
        ST_Y,
        ST_T,
        ST_A1,
        ST_DIV,
        ST_A2,
        ST_A3,
        ST_A4,
        ST_M,
        ST_MUL,
        ST_ACC,
        ST_RND,
        ST_SHF,
        ST_OUT
    } gbm_state_t;

    typedef struct packed {
        logic [31:0]      initial_price;
        logic [31:0]      step_drift;
        logic [VOL_W-1:0] step_vol;
    } gbm_cfg_t;

    typedef struct packed {
        logic                    en;
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } gbm_mul_req_t;

    // 2^(i/4) in q1.30
    function automatic logic [30:0] pow2_quarter(input logic [1:0] idx);
        logic [30:0] val;
        unique case (idx)
            2'd0: val = 31'd1073741824;
            2'd1: val = 31'd1276901417;
            2'd2: val = 31'd1518500250;
            2'd3: val = 31'd1805811301;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gbm_mult.sv =====
`default_nettype none

module gbm_mult
(
    input  logic                                clk,
    input  gbm_pkg::gbm_mul_req_t               req,
    output logic signed [gbm_pkg::PROD_W-1:0]   prod
);
    import gbm_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= req.a * req.b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gbm_core.sv =====
`default_nettype none

module gbm_core
#(
    parameter int PRICE_WIDTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  gbm_pkg::gbm_cfg_t                   cfg,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                start_path,
    input  logic signed [gbm_pkg::SAMPLE_W-1:0] normal_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gbm_pkg::OUT_W-1:0]           price,
    output logic                                saturated,
    output gbm_pkg::gbm_mul_req_t               mul_req,
    input  logic signed [gbm_pkg::PROD_W-1:0]   prod
);
    import gbm_pkg::*;

    localparam int WIDE   = (PRICE_WIDTH > 32) ? PRICE_WIDTH : 32;
    localparam int AW     = PRICE_WIDTH + 33;
    localparam int NCHUNK = (PRICE_WIDTH + 31) / 32;
    localparam int CH_W   = NCHUNK * 32;
    localparam int CNT_W  = $clog2(NCHUNK + 1);
    localparam logic [WIDE-1:0] PMAX_W = WIDE'({PRICE_WIDTH{1'b1}});

    gbm_state_t state_reg, state_next;

    logic [PRICE_WIDTH-1:0]    price_reg, price_next;
    logic                      sat_reg, sat_next;
    logic                      out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]          out_price_reg, out_price_next;
    logic                      out_sat_reg, out_sat_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [31:0]               x_reg, x_next;
    logic [27:0]               t_reg, t_next;
    logic [1:0]                idx_reg, idx_next;
    logic [5:0]                s_reg, s_next;
    logic [31:0]               m_reg, m_next;
    logic [CH_W-1:0]           pshift_reg, pshift_next;
    logic [AW-1:0]             acc_reg, acc_next;

    logic [WIDE-1:0]           init_w;
    logic [WIDE-1:0]           price_w;
    logic [35:0]               vz_q;
    logic signed [36:0]        x_wide;
    logic [31:0]               x_sat;
    logic signed [7:0]         k_raw;
    logic signed [7:0]         k_cl;
    logic [AW-1:0]             res;

    assign init_w  = WIDE'(cfg.initial_price);
    assign price_w = WIDE'(price_reg);

    // x = drift + round(vol * sample), clamped to q4.28
    assign vz_q   = prod[47:12];
    assign x_wide = {{5{cfg.step_drift[31]}}, cfg.step_drift} + {vz_q[35], vz_q}
                    + {36'b0, prod[11]};
    assign x_sat  = (x_wide[36:31] != {6{x_wide[31]}}) ?
                    (x_wide[36] ? Q428_MIN : Q428_MAX) : x_wide[31:0];

    // integer part of x*log2(e)
    assign k_raw = prod[65:58];
    assign k_cl  = (k_raw > K_MAX) ? K_MAX : ((k_raw < K_MIN) ? K_MIN : k_raw);

    assign res = acc_reg >> s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            price_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            price_reg     <= price_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg       <= sat_next;
        out_price_reg <= out_price_next;
        out_sat_reg   <= out_sat_next;
        sample_reg    <= sample_next;
        x_reg         <= x_next;
        t_reg         <= t_next;
        idx_reg       <= idx_next;
        s_reg         <= s_next;
        m_reg         <= m_next;
        pshift_reg    <= pshift_next;
        acc_reg       <= acc_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        price_next     = price_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg;
        out_price_next = out_price_reg;
        out_sat_next   = out_sat_reg;
        cnt_next       = cnt_reg;
        sample_next    = sample_reg;
        x_next         = x_reg;
        t_next         = t_reg;
        idx_next       = idx_reg;
        s_next         = s_reg;
        m_next         = m_reg;
        pshift_next    = pshift_reg;
        acc_next       = acc_reg;
        mul_req        = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (start_path)
                    begin
                        if (init_w > PMAX_W)
                        begin
                            price_next = '1;
                            sat_next   = 1'b1;
                        end
                        else
                        begin
                            price_next = init_w[PRICE_WIDTH-1:0];
                            sat_next   = 1'b0;
                        end
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        sample_next = normal_sample;
                        state_next  = ST_VZ;
                    end
                end
            end
            ST_VZ:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {2'b00, cfg.step_vol};
                mul_req.b  = {{(MUL_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
                state_next = ST_X;
            end
            ST_X:
            begin
                x_next     = x_sat;
                state_next = ST_Y;
            end
            ST_Y:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {x_reg[31], x_reg};
                mul_req.b  = {2'b00, LOG2E_Q30};
                state_next = ST_T;
            end
            ST_T:
            begin
                s_next     = SHIFT_BIAS - 6'(k_cl);
                idx_next   = prod[57:56];
                mul_req.en = 1'b1;
                mul_req.a  = {7'b0, prod[55:30]};
                mul_req.b  = {1'b0, LN2_Q32};
                state_next = ST_A1;
            end
            ST_A1:
            begin
                t_next     = prod[57:30];
                mul_req.en = 1'b1;
                mul_req.a  = {5'b0, prod[57:30]};
                mul_req.b  = {2'b00, 1'b1, 4'b0, prod[57:32]};
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // divide by three through the reciprocal
                mul_req.en = 1'b1;
                mul_req.a  = {1'b0, prod[61:30]};
                mul_req.b  = {1'b0, RECIP3_Q33};
                state_next = ST_A2;
            end
            ST_A2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {5'b0, t_reg};
                mul_req.b  = {2'b00, 1'b1, prod[62:33]};
                state_next = ST_A3;
            end
            ST_A3:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {5'b0, t_reg};
                mul_req.b  = {2'b00, 1'b1, prod[60:31]};
                state_next = ST_A4;
            end
            ST_A4:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {2'b00, pow2_quarter(idx_reg)};
                mul_req.b  = {2'b00, 1'b1, prod[59:30]};
                state_next = ST_M;
            end
            ST_M:
            begin
                m_next      = prod[61:30];
                pshift_next = CH_W'(price_reg);
                acc_next    = '0;
                cnt_next    = CNT_W'(NCHUNK);
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                // high price word first
                mul_req.en = 1'b1;
                mul_req.a  = {1'b0, pshift_reg[CH_W-1 -: 32]};
                mul_req.b  = {1'b0, m_reg};
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next    = {acc_reg[AW-33:0], 32'b0} + AW'(prod[63:0]);
                pshift_next = pshift_reg << 32;
                cnt_next    = cnt_reg - CNT_W'(1);
                state_next  = (cnt_reg == CNT_W'(1)) ? ST_RND : ST_MUL;
            end
            ST_RND:
            begin
                acc_next   = acc_reg + (AW'(1) << (s_reg - 6'd1));
                state_next = ST_SHF;
            end
            ST_SHF:
            begin
                if (|res[AW-1:PRICE_WIDTH])
                begin
                    price_next = '1;
                    sat_next   = 1'b1;
                end
                else
                begin
                    price_next = res[PRICE_WIDTH-1:0];
                    sat_next   = 1'b0;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_price_next = price_w[OUT_W-1:0];
                    out_sat_next   = sat_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign price     = out_price_reg;
    assign saturated = out_sat_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gbm_price_path_step.sv =====
// channel   | valid      | stall      | payload
// ----------+------------+------------+------------------------------
// input     | in_valid   | in_stall   | start_path, normal_sample
// output    | out_valid  | out_stall  | price, saturated
// config    | cfg_we     | -          | cfg_index, cfg_data
//
// a path-start item loads the initial price and posts it from ST_OUT; a step item runs
// from ST_VZ to ST_OUT, with one ST_MUL/ST_ACC pass per 32-bit price word, on the one
// shared 33x33 multiplier that runs the vol*sample product, the exponent, the exp polynomial
// and the price product in turn; the block takes no new item until the last one is posted
// reset clears the path price to zero and loads the register defaults; in_stall is high
// from accept until the result is in the output register, and a stalled output holds it there
`default_nettype none

module gbm_price_path_step
#(
    parameter int PRICE_WIDTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [gbm_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                start_path,
    input  logic signed [gbm_pkg::SAMPLE_W-1:0] normal_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gbm_pkg::OUT_W-1:0]           price,
    output logic                                saturated
);
    import gbm_pkg::*;

    localparam int WIDE = (PRICE_WIDTH > 32) ? PRICE_WIDTH : 32;
    localparam logic [WIDE-1:0] PMAX_W = WIDE'({PRICE_WIDTH{1'b1}});

    gbm_cfg_t                 cfg_reg, cfg_next;
    gbm_mul_req_t             mul_req;
    logic signed [PROD_W-1:0] prod;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INITIAL_PRICE: cfg_next.initial_price = cfg_data;
                CFG_STEP_DRIFT:    cfg_next.step_drift    = cfg_data;
                CFG_STEP_VOL:      cfg_next.step_vol      = cfg_data[VOL_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_price <= INIT_PRICE_RESET;
            cfg_reg.step_drift    <= '0;
            cfg_reg.step_vol      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gbm_core
    #(
        .PRICE_WIDTH (PRICE_WIDTH)
    )
    u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_path    (start_path),
        .normal_sample (normal_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .price         (price),
        .saturated     (saturated),
        .mul_req       (mul_req),
        .prod          (prod)
    );

    gbm_mult u_mult
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted item did not make the block busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> price == PMAX_W[OUT_W-1:0])
        else $error("saturated item without the maximum price");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item at work");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("block went idle without posting its result");
`endif

endmodule

`default_nettype wire

// ===== tb/gbm_price_path_step_check.sv =====
`timescale 1ns / 100ps

module gbm_price_path_step_check
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [gbm_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                start_path,
    input  logic signed [gbm_pkg::SAMPLE_W-1:0] normal_sample,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [gbm_pkg::OUT_W-1:0]           price,
    input  logic                                saturated,
    output int                                  mismatch_count,
    output int                                  outstanding
);

    localparam logic signed [63:0] LOG2E     = 64'sd1549082005;
    localparam logic signed [63:0] X_MAX     = 64'sd2147483647;
    localparam logic signed [63:0] X_MIN     = -64'sd2147483648;
    localparam logic [63:0]        LN2       = 64'd2977044472;
    localparam logic [63:0]        ONE       = 64'd1073741824;
    localparam logic [127:0]       PRICE_TOP = 128'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] price;
        logic        sat;
    } path_result_t;

    logic [31:0]        init_price;
    logic signed [31:0] drift;
    logic [30:0]        vol;
    logic [31:0]        path_price;

    path_result_t expected_prices[$];
    path_result_t next_res;
    path_result_t want;

    function automatic path_result_t next_path_price(input logic sp,
                                                     input logic signed [15:0] z,
                                                     input logic [31:0] held);
        logic signed [63:0] zs;
        logic signed [63:0] vs;
        logic signed [63:0] ds;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic [63:0]        yb;
        logic [63:0]        t;
        logic [63:0]        a;
        logic [63:0]        root;
        logic [63:0]        m;
        logic [127:0]       prod;
        logic [127:0]       scaled;
        int                 k;
        int                 s;
        path_result_t       res;
        res.sat = 1'b0;
        if (sp)
        begin
            res.price = init_price;
        end
        else
        begin
            zs = 64'(z);
            vs = {33'd0, vol};
            ds = 64'(drift);
            x  = ds + ((vs * zs + 64'sd2048) >>> 12);
            if (x > X_MAX)
                x = X_MAX;
            if (x < X_MIN)
                x = X_MIN;
            y  = (x * LOG2E) >>> 30;
            yb = y + 64'd4294967296;
            k  = int'(yb[35:28]) - 16;
            // 2^frac from quarter root table and taylor series
            t = ({38'd0, yb[25:0]} * LN2) >> 30;
            a = ONE + t / 4;
            a = ONE + ((t * a) >> 30) / 3;
            a = ONE + ((t * a) >> 31);
            a = ONE + ((t * a) >> 30);
            case (yb[27:26])
                2'd0:    root = 64'd1073741824;
                2'd1:    root = 64'd1276901417;
                2'd2:    root = 64'd1518500250;
                default: root = 64'd1805811301;
            endcase
            m = (root * a) >> 30;
            if (k > 11)
                k = 11;
            if (k < -12)
                k = -12;
            s      = 30 - k;
            prod   = {96'd0, held} * {64'd0, m} + (128'd1 << (s - 1));
            scaled = prod >> s;
            if (scaled > PRICE_TOP)
            begin
                res.price = '1;
                res.sat   = 1'b1;
            end
            else
            begin
                res.price = scaled[31:0];
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_price     <= gbm_pkg::INIT_PRICE_RESET;
            drift          <= '0;
            vol            <= '0;
            path_price     <= '0;
            mismatch_count <= 0;
            outstanding    <= 0;
            expected_prices.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gbm_pkg::CFG_INITIAL_PRICE: init_price <= cfg_data;
                    gbm_pkg::CFG_STEP_DRIFT:    drift      <= cfg_data;
                    gbm_pkg::CFG_STEP_VOL:      vol        <= cfg_data[30:0];
                    default:                    ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                next_res = next_path_price(start_path, normal_sample, path_price);
                path_price <= next_res.price;
                expected_prices.push_back(next_res);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_prices.size() == 0)
                begin
                    $display("%0t: unexpected item price %h saturated %b",
                             $time, price, saturated);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_prices.pop_front();
                    if (price !== want.price)
                        $display("%0t: price expected %h actual %h",
                                 $time, want.price, price);
                    if (saturated !== want.sat)
                        $display("%0t: saturated expected %b actual %b",
                                 $time, want.sat, saturated);
                    if (price !== want.price || saturated !== want.sat)
                        mismatch_count <= mismatch_count + 1;
                end
            end
            outstanding <= expected_prices.size();
        end
    end

endmodule

// ===== tb/gbm_price_path_step_test.sv =====
`timescale 1ns / 100ps

module gbm_price_path_step_test;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [1:0]                          cfg_index;
    logic [gbm_pkg::CFG_W-1:0]           cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    logic                                start_path;
    logic signed [gbm_pkg::SAMPLE_W-1:0] normal_sample;
    logic                                out_valid;
    logic                                out_stall;
    logic [gbm_pkg::OUT_W-1:0]           price;
    logic                                saturated;
    logic                                calm;
    int                                  mismatch_count;
    int                                  outstanding;

    gbm_price_path_step u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_path    (start_path),
        .normal_sample (normal_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .price         (price),
        .saturated     (saturated)
    );

    gbm_price_path_step_check u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_path     (start_path),
        .normal_sample  (normal_sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .price          (price),
        .saturated      (saturated),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 22);
    end

    task automatic send_item(input logic sp, input logic [15:0] z);
        int gap;
        if (!calm && $urandom_range(0, 99) < 22)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        start_path    <= sp;
        normal_sample <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] draw_sample();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 16384)) - 16'd8192;
    endfunction

    initial
    begin
        int n;
        int len;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= gbm_pkg::CFG_INITIAL_PRICE;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        start_path    <= 1'b0;
        normal_sample <= '0;
        calm          <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // steps before any path start stay at zero
        send_item(1'b0, 16'h7FFF);
        send_item(1'b0, 16'h8000);
        send_item(1'b1, 16'h1234);
        send_item(1'b0, 16'h0000);
        drain();
        write_reg(gbm_pkg::CFG_INITIAL_PRICE, 32'd100 << 16);
        write_reg(gbm_pkg::CFG_STEP_DRIFT, 32'd53687);
        write_reg(gbm_pkg::CFG_STEP_VOL, 32'd5368709);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_item(1'b1, 16'h0000);
        send_item(1'b0, 16'h7FFF);
        send_item(1'b0, 16'h8000);
        send_item(1'b0, 16'h0001);
        send_item(1'b0, 16'hFFFF);
        send_item(1'b0, 16'h0000);

        // exponent clamped high, then low
        drain();
        write_reg(gbm_pkg::CFG_STEP_DRIFT, 32'h7FFF_FFFF);
        write_reg(gbm_pkg::CFG_STEP_VOL, 32'hFFFF_FFFF);
        send_item(1'b1, 16'h5555);
        send_item(1'b0, 16'h7FFF);
        send_item(1'b0, 16'h0000);
        send_item(1'b0, 16'h8000);

        // underflow drives the path to zero
        drain();
        write_reg(gbm_pkg::CFG_STEP_DRIFT, 32'h8000_0000);
        write_reg(gbm_pkg::CFG_STEP_VOL, 32'h0000_0000);
        send_item(1'b1, 16'hAAAA);
        repeat (4) send_item(1'b0, 16'h0000);

        drain();
        write_reg(gbm_pkg::CFG_INITIAL_PRICE, 32'h0000_0000);
        write_reg(gbm_pkg::CFG_STEP_DRIFT, 32'h0000_0000);
        send_item(1'b1, 16'h0000);
        send_item(1'b0, 16'h7FFF);
        drain();
        write_reg(gbm_pkg::CFG_INITIAL_PRICE, 32'hFFFF_FFFF);
        send_item(1'b1, 16'h0000);
        send_item(1'b0, 16'h0000);
        drain();
        write_reg(gbm_pkg::CFG_INITIAL_PRICE, 32'h0000_0001);
        send_item(1'b1, 16'h0000);
        send_item(1'b0, 16'h0100);

        // random paths under several register settings
        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            calm <= (phase == 3);
            write_reg(gbm_pkg::CFG_INITIAL_PRICE, (phase % 4 == 0) ? $urandom
                      : $urandom_range(32'h0001_0000, 32'h0100_0000));
            write_reg(gbm_pkg::CFG_STEP_DRIFT, (phase % 3 == 0) ? $urandom
                      : 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21));
            write_reg(gbm_pkg::CFG_STEP_VOL, (phase % 3 == 1) ? $urandom
                      : $urandom_range(0, 1 << 24));
            n = 0;
            while (n < 90)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(1'($urandom_range(0, 1)), 16'($urandom));
                    n++;
                end
                else
                begin
                    send_item(1'b1, 16'($urandom));
                    len = $urandom_range(1, 20);
                    repeat (len) send_item(1'b0, draw_sample());
                    n += len + 1;
                end
            end
        end

        drain();
        calm <= 1'b0;
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== gbm_price_path_step.f =====
hw/rtl/gbm_pkg.sv
hw/rtl/gbm_mult.sv
hw/rtl/gbm_core.sv
hw/rtl/gbm_price_path_step.sv
tb/gbm_price_path_step_check.sv
tb/gbm_price_path_step_test.sv
